// ----- design/mat_pkg.sv -----
// Shared types and constants for the adaptive mean threshold unit.
`default_nettype none

package mat_pkg;

  localparam int WINDOW_DEF     = 21;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int OFS_W = 9;
  localparam int IDX_W = 2;
  localparam int OUT_W = 8;

  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;
  localparam int OFFSET_RST = 10;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_OFFSET = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef struct packed {
    logic pix_item;
    logic emit;
    logic forced;
    logic frame_end;
    logic first_row;
    logic col_zero;
    logic col_ge_span;
    logic has_old;
    logic fwd;
  } s1_ctl_t;

  typedef struct packed {
    logic emit;
    logic forced;
    logic frame_end;
  } s2_ctl_t;

endpackage

`default_nettype wire

// ----- design/mat_row_store.sv -----
// Line store holding the most recent window of image lines.
`default_nettype none

module mat_row_store import mat_pkg::*; #(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int SPAN     = 2 * (WINDOW / 2) + 1,
  localparam int DEPTH    = SPAN * MAX_WIDTH,
  localparam int AW       = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    ctr_addr,
  output logic [PIX_W-1:0] old_pix,
  output logic [PIX_W-1:0] ctr_pix
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      old_pix <= mem[wr_addr];
      ctr_pix <= mem[ctr_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/mat_ctrl.sv -----
// Position counters, frame tracking and border decisions for each accepted item.
`default_nettype none

module mat_ctrl import mat_pkg::*; #(
  parameter int WINDOW     = WINDOW_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int HALF      = WINDOW / 2,
  localparam int SPAN      = 2 * HALF + 1,
  localparam int CW        = $clog2(MAX_WIDTH),
  localparam int RW        = $clog2(MAX_HEIGHT),
  localparam int FW_W      = $clog2(MAX_WIDTH + 1),
  localparam int FH_W      = $clog2(MAX_HEIGHT + 1),
  localparam int PW        = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int SW        = $clog2(SPAN),
  localparam int AW        = $clog2(SPAN * MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             acc,
  input  logic             adv,
  input  op_t              op,
  input  logic [PIX_W-1:0] pix_in,
  input  logic [CFG_W-1:0] image_width,
  input  logic [CFG_W-1:0] image_height,
  output s1_ctl_t          s1,
  output logic [CW-1:0]    s1_col,
  output logic [PIX_W-1:0] s1_pixel,
  output logic             rs_wr_en,
  output logic [AW-1:0]    rs_wr_addr,
  output logic [AW-1:0]    rs_ctr_addr,
  output logic             cs_rd_en,
  output logic [CW-1:0]    cs_rd_addr
);

  logic [FW_W-1:0]   frame_w;
  logic [FH_W-1:0]   frame_h;
  logic [PW-1:0]     lag;
  logic signed [FW_W:0] col_lim;
  logic signed [FH_W:0] row_lim;
  logic              in_frame;
  logic              input_done;
  logic [RW-1:0]     in_row;
  logic [CW-1:0]     in_col;
  logic [SW-1:0]     in_slot;
  logic [PW-1:0]     in_pos;
  logic [RW-1:0]     out_row;
  logic [CW-1:0]     out_col;
  logic [SW-1:0]     out_slot;

  logic              is_pix;
  logic              start;
  int                fw_c;
  int                fh_c;
  logic [FW_W-1:0]   fw_e;
  logic [FH_W-1:0]   fh_e;
  logic [RW-1:0]     r_e;
  logic [CW-1:0]     c_e;
  logic [SW-1:0]     slot_e;
  logic [PW-1:0]     q_e;
  logic              emit_pix;
  logic              emit_drain;
  logic              border;
  logic              last_out;

  always_comb begin
    is_pix = (op == OP_PIXEL);
    start  = is_pix && (!in_frame || input_done);

    fw_c = int'(image_width);
    if (fw_c < 1) fw_c = 1;
    if (fw_c > MAX_WIDTH) fw_c = MAX_WIDTH;
    fh_c = int'(image_height);
    if (fh_c < 1) fh_c = 1;
    if (fh_c > MAX_HEIGHT) fh_c = MAX_HEIGHT;

    fw_e   = start ? FW_W'(fw_c) : frame_w;
    fh_e   = start ? FH_W'(fh_c) : frame_h;
    r_e    = start ? '0 : in_row;
    c_e    = start ? '0 : in_col;
    slot_e = start ? '0 : in_slot;
    q_e    = start ? '0 : in_pos;

    emit_pix   = is_pix && !start && (q_e >= lag);
    emit_drain = !is_pix && in_frame && input_done;
    border = (int'(out_row) < HALF) || (int'(out_row) >= int'(row_lim)) ||
             (int'(out_col) < HALF) || (int'(out_col) >= int'(col_lim));
    last_out = (int'(out_row) == int'(frame_h) - 1) &&
               (int'(out_col) == int'(frame_w) - 1);

    rs_wr_en    = acc && is_pix;
    rs_wr_addr  = AW'(int'(slot_e) * MAX_WIDTH + int'(c_e));
    rs_ctr_addr = AW'(int'(out_slot) * MAX_WIDTH + int'(out_col));
    cs_rd_en    = acc && is_pix;
    cs_rd_addr  = c_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      input_done <= 1'b0;
      in_row     <= '0;
      in_col     <= '0;
      in_slot    <= '0;
      in_pos     <= '0;
      out_row    <= '0;
      out_col    <= '0;
      out_slot   <= '0;
    end else if (acc) begin
      if (start) begin
        frame_w    <= fw_e;
        frame_h    <= fh_e;
        lag        <= PW'(HALF * fw_c + HALF);
        col_lim    <= (FW_W+1)'(fw_c - HALF - 1);
        row_lim    <= (FH_W+1)'(fh_c - HALF - 1);
        in_frame   <= 1'b1;
        out_row    <= '0;
        out_col    <= '0;
        out_slot   <= '0;
      end
      if (is_pix) begin
        in_pos <= q_e + 1'b1;
        if (int'(c_e) + 1 >= int'(fw_e)) begin
          in_col     <= '0;
          in_row     <= r_e + 1'b1;
          in_slot    <= (int'(slot_e) == SPAN - 1) ? '0 : slot_e + 1'b1;
          input_done <= (int'(r_e) + 1 >= int'(fh_e));
        end else begin
          in_col     <= c_e + 1'b1;
          in_row     <= r_e;
          in_slot    <= slot_e;
          input_done <= 1'b0;
        end
      end
      if (emit_pix || emit_drain) begin
        if (last_out) begin
          in_frame <= 1'b0;
        end
        if (int'(out_col) + 1 >= int'(frame_w)) begin
          out_col  <= '0;
          out_row  <= out_row + 1'b1;
          out_slot <= (int'(out_slot) == SPAN - 1) ? '0 : out_slot + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (adv) begin
      s1.pix_item    <= acc && is_pix;
      s1.emit        <= acc && (emit_pix || emit_drain);
      s1.forced      <= emit_drain || border;
      s1.frame_end   <= last_out;
      s1.first_row   <= (r_e == '0);
      s1.col_zero    <= (c_e == '0);
      s1.col_ge_span <= (int'(c_e) >= SPAN);
      s1.has_old     <= (int'(r_e) >= SPAN);
      s1.fwd         <= s1.pix_item && (s1_col == c_e);
      s1_col         <= c_e;
      s1_pixel       <= pix_in;
    end
  end

  a_col_in_line: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (int'(in_col) < int'(frame_w)))
    else $error("input column beyond line width");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (int'(in_slot) < SPAN) && (int'(out_slot) < SPAN))
    else $error("line slot out of range");

  a_drain_keeps_input: assert property (@(posedge clk) disable iff (rst)
    (acc && op == OP_DRAIN) |=> $stable(in_pos))
    else $error("drain moved the input position");

endmodule

`default_nettype wire

// ----- design/mat_window.sv -----
// Column sums, running window sum and threshold product.
`default_nettype none

module mat_window import mat_pkg::*; #(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int HALF     = WINDOW / 2,
  localparam int SPAN     = 2 * HALF + 1,
  localparam int AREA     = WINDOW * WINDOW,
  localparam int CW       = $clog2(MAX_WIDTH),
  localparam int CS_W     = $clog2(SPAN * 255 + 1),
  localparam int WS_W     = $clog2(SPAN * SPAN * 255 + 1),
  localparam int PRW      = 12 + $clog2(AREA + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  cs_rd_en,
  input  logic [CW-1:0]         cs_rd_addr,
  input  s1_ctl_t               s1,
  input  logic [CW-1:0]         s1_col,
  input  logic [PIX_W-1:0]      s1_pixel,
  input  logic [PIX_W-1:0]      old_pix,
  input  logic [PIX_W-1:0]      ctr_pix,
  input  logic signed [OFS_W-1:0] offset,
  output s2_ctl_t               s2,
  output logic [WS_W-1:0]       s2_ws,
  output logic signed [PRW-1:0] s2_prod
);

  logic [CS_W-1:0] cs_mem [MAX_WIDTH];
  logic [CS_W-1:0] cs_rd;
  logic [CS_W-1:0] cs_last;
  logic [CS_W-1:0] dline [SPAN];
  logic [WS_W-1:0] ws;

  logic [CS_W-1:0] base;
  logic [CS_W-1:0] cs_new;
  logic [WS_W-1:0] ws_new;
  logic signed [PRW-1:0] prod;

  always_comb begin
    base   = s1.first_row ? '0 : (s1.fwd ? cs_last : cs_rd);
    cs_new = CS_W'(int'(base) + int'(s1_pixel) - (s1.has_old ? int'(old_pix) : 0));
    ws_new = WS_W'((s1.col_zero ? 0 : int'(ws)) + int'(cs_new) -
                   (s1.col_ge_span ? int'(dline[SPAN-1]) : 0));
    prod   = PRW'((int'(ctr_pix) + int'(offset) + 1) * AREA);
  end

  always_ff @(posedge clk) begin
    if (cs_rd_en) begin
      cs_rd <= cs_mem[cs_rd_addr];
    end
    if (adv && s1.pix_item) begin
      cs_mem[s1_col] <= cs_new;
      cs_last        <= cs_new;
      ws             <= ws_new;
      dline[0]       <= cs_new;
      for (int k = 1; k < SPAN; k++) begin
        dline[k] <= dline[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else if (adv) begin
      s2.emit      <= s1.emit;
      s2.forced    <= s1.forced;
      s2.frame_end <= s1.frame_end;
      s2_ws        <= ws_new;
      s2_prod      <= prod;
    end
  end

endmodule

`default_nettype wire

// ----- design/mean_adaptive_threshold_unit.sv -----
// Top level of the adaptive mean threshold unit.
//
//  channel   dir  handshake               payload
//  s_*       in   s_tvalid / s_tready     s_tdata: pixel; s_tuser: operation
//  m_*       out  m_tvalid / m_tready     m_tdata: is_white; m_tlast: frame_end
//  cfg_*     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One transaction per cycle is accepted while the output is not stalled; the accepting edge
// registers counters and memory reads, then column and window sums, then the compare result.
// The line store is never cleared; column sums read as zero on the first line of a frame.
// Reset is synchronous; both ready outputs are low in reset and input is taken the cycle after.
// A stalled result holds the pipeline only when a new result would overwrite it.
`default_nettype none

module mean_adaptive_threshold_unit import mat_pkg::*; #(
  parameter int WINDOW     = WINDOW_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [PIX_W-1:0] s_tdata,   // [7:0] pixel
  input  logic             s_tuser,   // [0] operation
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // [0] is_white, [7:1] zero
  output logic             m_tlast,   // frame_end
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int HALF = WINDOW / 2;
  localparam int SPAN = 2 * HALF + 1;
  localparam int AREA = WINDOW * WINDOW;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int AW   = $clog2(SPAN * MAX_WIDTH);
  localparam int WS_W = $clog2(SPAN * SPAN * 255 + 1);
  localparam int PRW  = 12 + $clog2(AREA + 1);

  logic [CFG_W-1:0]        image_width;
  logic [CFG_W-1:0]        image_height;
  logic signed [OFS_W-1:0] offset;

  logic             acc;
  logic             adv;
  s1_ctl_t          s1;
  logic [CW-1:0]    s1_col;
  logic [PIX_W-1:0] s1_pixel;
  logic             rs_wr_en;
  logic [AW-1:0]    rs_wr_addr;
  logic [AW-1:0]    rs_ctr_addr;
  logic             cs_rd_en;
  logic [CW-1:0]    cs_rd_addr;
  logic [PIX_W-1:0] old_pix;
  logic [PIX_W-1:0] ctr_pix;
  s2_ctl_t          s2;
  logic [WS_W-1:0]  s2_ws;
  logic signed [PRW-1:0] s2_prod;
  logic             is_white;
  logic             black;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(WIDTH_RST);
      image_height <= CFG_W'(HEIGHT_RST);
      offset       <= OFS_W'(OFFSET_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH: begin
          image_width <= cfg_data;
        end
        REG_HEIGHT: begin
          image_height <= cfg_data;
        end
        REG_OFFSET: begin
          offset <= cfg_data[OFS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign adv      = !(s2.emit && m_tvalid && !m_tready);
  assign s_tready = adv && !rst;
  assign acc      = s_tvalid && s_tready;

  mat_ctrl #(
    .WINDOW     (WINDOW),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .acc          (acc),
    .adv          (adv),
    .op           (op_t'(s_tuser)),
    .pix_in       (s_tdata),
    .image_width  (image_width),
    .image_height (image_height),
    .s1           (s1),
    .s1_col       (s1_col),
    .s1_pixel     (s1_pixel),
    .rs_wr_en     (rs_wr_en),
    .rs_wr_addr   (rs_wr_addr),
    .rs_ctr_addr  (rs_ctr_addr),
    .cs_rd_en     (cs_rd_en),
    .cs_rd_addr   (cs_rd_addr)
  );

  mat_row_store #(
    .WINDOW    (WINDOW),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_row_store (
    .clk      (clk),
    .wr_en    (rs_wr_en),
    .wr_addr  (rs_wr_addr),
    .wr_data  (s_tdata),
    .rd_en    (acc),
    .ctr_addr (rs_ctr_addr),
    .old_pix  (old_pix),
    .ctr_pix  (ctr_pix)
  );

  mat_window #(
    .WINDOW    (WINDOW),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .cs_rd_en   (cs_rd_en),
    .cs_rd_addr (cs_rd_addr),
    .s1         (s1),
    .s1_col     (s1_col),
    .s1_pixel   (s1_pixel),
    .old_pix    (old_pix),
    .ctr_pix    (ctr_pix),
    .offset     (offset),
    .s2         (s2),
    .s2_ws      (s2_ws),
    .s2_prod    (s2_prod)
  );

  assign black    = int'(s2_ws) >= int'(s2_prod);
  assign is_white = s2.forced || !black;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && s2.emit) begin
      m_tvalid <= 1'b1;
      m_tdata  <= OUT_W'(is_white);
      m_tlast  <= s2.frame_end;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_mean_adaptive_threshold_unit.sv -----
// Testbench for the adaptive mean threshold unit: random framed pixel streams checked against a predictor.
`timescale 1ns / 100ps

import mat_pkg::*;

typedef struct {
  bit white;
  bit last;
} thr_result_t;

class thr_scoreboard;
  localparam int HALF = WINDOW_DEF / 2;
  localparam int SPAN = 2 * HALF + 1;

  int reg_w = WIDTH_RST;
  int reg_h = HEIGHT_RST;
  int ofs = OFFSET_RST;
  bit [7:0] lines [SPAN*MAX_WIDTH_DEF];
  int col_sum [MAX_WIDTH_DEF];
  int win_sum, in_row, in_col, out_pos, fw = WIDTH_RST, fh = HEIGHT_RST;
  bit in_frame, input_done;
  thr_result_t pending [$];
  int errors, checked, frames;

  function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_WIDTH: reg_w = val;
      REG_HEIGHT: reg_h = val;
      REG_OFFSET: ofs = $signed(val[OFS_W-1:0]);
      default: ;
    endcase
  endfunction

  function int clamp_dim(int v, int mx);
    return (v < 1) ? 1 : (v > mx) ? mx : v;
  endfunction

  function void push_result(int p, bit white);
    thr_result_t res;
    res.white = white;
    res.last = (p == fw * fh - 1);
    pending.push_back(res);
    out_pos = p + 1;
    if (res.last) in_frame = 0;
  endfunction

  function bit decide(int p);
    int j, i, mean, pix;
    j = p / fw;
    i = p % fw;
    if (j < HALF || j >= fh - HALF - 1 || i < HALF || i >= fw - HALF - 1) return 1;
    mean = win_sum / (WINDOW_DEF * WINDOW_DEF);
    pix = lines[(j % SPAN) * MAX_WIDTH_DEF + i];
    return !(pix < mean - ofs);
  endfunction

  function void note_item(op_t op, bit [7:0] pix);
    int r, c, old, q, lag;
    if (op == OP_DRAIN) begin
      if (in_frame && input_done && out_pos < fw * fh) push_result(out_pos, 1'b1);
      return;
    end
    if (!in_frame || input_done) begin
      fw = clamp_dim(reg_w, MAX_WIDTH_DEF);
      fh = clamp_dim(reg_h, MAX_HEIGHT_DEF);
      foreach (col_sum[k]) col_sum[k] = 0;
      win_sum = 0;
      in_row = 0;
      in_col = 0;
      out_pos = 0;
      in_frame = 1;
      input_done = 0;
      frames++;
    end
    r = in_row;
    c = in_col;
    old = (r >= SPAN) ? lines[(r % SPAN) * MAX_WIDTH_DEF + c] : 0;
    lines[(r % SPAN) * MAX_WIDTH_DEF + c] = pix;
    col_sum[c] = col_sum[c] + pix - old;
    if (c == 0) win_sum = 0;
    win_sum += col_sum[c];
    if (c >= SPAN) win_sum -= col_sum[c - SPAN];
    q = r * fw + c;
    lag = HALF * fw + HALF;
    in_col = c + 1;
    if (in_col >= fw) begin
      in_col = 0;
      in_row = r + 1;
      if (in_row >= fh) input_done = 1;
    end
    if (q >= lag) push_result(q - lag, decide(q - lag));
  endfunction

  function void check_result(bit white, bit last);
    thr_result_t exp_res;
    checked++;
    if (pending.size() == 0) begin
      $error("unexpected result: is_white=%0d frame_end=%0d", white, last);
      errors++;
      return;
    end
    exp_res = pending.pop_front();
    if (white != exp_res.white) begin
      $error("is_white: expected %0d, actual %0d", exp_res.white, white);
      errors++;
    end
    if (last != exp_res.last) begin
      $error("frame_end: expected %0d, actual %0d", exp_res.last, last);
      errors++;
    end
  endfunction
endclass

module tb_mean_adaptive_threshold_unit;
  localparam int LIMIT = 1000000;
  localparam int SETTLE = 10;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [PIX_W-1:0] s_tdata = 0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;

  thr_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int cycles = 0;

  mean_adaptive_threshold_unit u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_mean_adaptive_threshold_unit: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[0], m_tlast);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(op_t op, bit [7:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= pix;
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, pix);
  endtask

  task automatic write_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    s_tvalid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_frame(int w, int h, int mode, int drains, bit noisy);
    bit [7:0] pix;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (noisy && $urandom_range(29) == 0) send_item(OP_DRAIN, $urandom);
        if (mode == 0) pix = $urandom;
        else pix = ((c * 5 + r * 3) % 256) ^ $urandom_range(31);
        send_item(OP_PIXEL, pix);
      end
    end
    repeat (drains) send_item(OP_DRAIN, $urandom);
  endtask

  initial begin
    int w, h, ofs, lag, drains;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tiny frames from saturated sizes, drains outside a frame, unused index
    send_item(OP_DRAIN, 8'h00);
    wait_idle();
    write_cfg(REG_WIDTH, 11'd0);
    write_cfg(REG_HEIGHT, 11'd0);
    write_cfg(REG_OFFSET, 11'h100);
    write_cfg(REG_UNUSED, 11'h7FF);
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_DRAIN, 8'h00);
    send_item(OP_DRAIN, 8'hFF);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_DRAIN, 8'h00);
    wait_idle();
    write_cfg(REG_WIDTH, 11'd1);
    write_cfg(REG_HEIGHT, 11'd24);
    write_cfg(REG_OFFSET, 11'h0FF);
    run_frame(1, 24, 0, 21, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 65 : 0;
      recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 34 : 0;
      w = (ph == 2) ? 24 : $urandom_range(24, 26);
      h = (ph == 1) ? 22 : 24;
      ofs = (ph == 0) ? -255 : (ph == 1) ? $urandom_range(0, 60) - 30 : 255;
      lag = (WINDOW_DEF / 2) * w + WINDOW_DEF / 2;
      drains = (ph == 0) ? 20 : (ph == 1) ? 5 : lag + 3;
      write_cfg(REG_WIDTH, w);
      write_cfg(REG_HEIGHT, h);
      write_cfg(REG_OFFSET, ofs & 9'h1FF);
      if (ph == 2) hold_left = 400;
      run_frame(w, h, ph % 2, drains, 1'b1);
      wait_idle();
    end

    if (sb.pending.size() != 0) sb.errors++;
    $display("Covered %0d frames, %0d results checked, sizes from one pixel up to 26 wide,",
             sb.frames, sb.checked);
    $display("with dropped tails, full drains, idle phases and a long output stall.");
    if (sb.errors == 0) begin
      $display("tb_mean_adaptive_threshold_unit: clean");
    end else begin
      $display("tb_mean_adaptive_threshold_unit: errors");
    end
    $finish;
  end
endmodule
